// ===== rtl/laser_range_reply_decoder_core_macros.svh =====
// Assertion helpers shared by the decoder RTL
`ifndef LASER_RANGE_REPLY_DECODER_CORE_MACROS_SVH
`define LASER_RANGE_REPLY_DECODER_CORE_MACROS_SVH

// same-cycle implication, checked out of reset
`define LRRD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define LRRD_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) pre |=> post) \
    else $error(msg);

`endif

// ===== rtl/lrrd_pkg.sv =====
package lrrd_pkg;

  localparam int unsigned READING_LIMIT_DEF = 8192;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned STEP_W  = 10;
  localparam int unsigned CLUS_W  = 7;
  localparam int unsigned VALUE_W = 12;
  localparam int unsigned COUNT_W = 14;
  localparam int unsigned DIGIT_W = 6;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [BYTE_W-1:0] CHAR_LF   = 8'h0A;
  localparam logic [BYTE_W-1:0] CHAR_ZERO = 8'h30;

  localparam logic [CFG_IDX_W-1:0] CFG_START_STEP   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_END_STEP     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CLUSTER_SIZE = 2'd2;

  localparam logic [STEP_W-1:0] START_STEP_RST   = 10'd0;
  localparam logic [STEP_W-1:0] END_STEP_RST     = 10'd768;
  localparam logic [CLUS_W-1:0] CLUSTER_SIZE_RST = 7'd1;

  typedef enum logic [1:0] {
    KIND_READING    = 2'd0,
    KIND_END_OK     = 2'd1,
    KIND_TOO_MANY   = 2'd2,
    KIND_STATUS_ERR = 2'd3
  } lrrd_kind_e;

  // step span end-start as sign and magnitude, cluster size forced non-zero
  typedef struct packed {
    logic              neg;
    logic [STEP_W-1:0] mag;
    logic [CLUS_W-1:0] clus;
  } lrrd_bound_t;

  typedef struct packed {
    logic               emit;
    lrrd_kind_e         kind;
    logic [VALUE_W-1:0] value;
    logic [COUNT_W-1:0] count;
    logic               last;
  } lrrd_res_t;

endpackage

// ===== rtl/lrrd_cfg.sv =====
module lrrd_cfg
  import lrrd_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [STEP_W-1:0]    cfg_data_i,
  output lrrd_bound_t          bound_o
);

  logic [STEP_W-1:0] start_q;
  logic [STEP_W-1:0] end_q;
  logic [CLUS_W-1:0] clus_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q <= START_STEP_RST;
      end_q   <= END_STEP_RST;
      clus_q  <= CLUSTER_SIZE_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_START_STEP:   start_q <= cfg_data_i;
        CFG_END_STEP:     end_q   <= cfg_data_i;
        CFG_CLUSTER_SIZE: clus_q  <= cfg_data_i[CLUS_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    bound_o.neg  = end_q < start_q;
    bound_o.mag  = bound_o.neg ? (start_q - end_q) : (end_q - start_q);
    bound_o.clus = (clus_q == '0) ? CLUS_W'(1) : clus_q;
  end

endmodule

// ===== rtl/lrrd_parser.sv =====
module lrrd_parser
  import lrrd_pkg::*;
#(
  parameter int unsigned ReadingLimit = READING_LIMIT_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  logic [BYTE_W-1:0] rx_byte_i,
  input  logic              start_of_reply_i,
  input  lrrd_bound_t       bound_i,
  output lrrd_res_t         res_o
);

`include "laser_range_reply_decoder_core_macros.svh"

  localparam int unsigned CntW  = $clog2(ReadingLimit + 1);
  localparam int unsigned ProdW = CntW + CLUS_W;
  localparam logic [CntW-1:0] CntMax = CntW'(ReadingLimit);

  typedef enum logic [2:0] {
    PH_ECHO         = 3'd0,
    PH_STATUS_FIRST = 3'd1,
    PH_STATUS_REST  = 3'd2,
    PH_DATA         = 3'd3,
    PH_DONE         = 3'd4
  } phase_e;

  phase_e               phase_q, phase_d, phase_cur;
  logic                 plf_q, plf_d, plf_cur;
  logic                 sec_q, sec_d, sec_cur;
  logic [DIGIT_W-1:0]   hi_q, hi_d, hi_cur;
  logic [CntW-1:0]      cnt_q, cnt_d, cnt_cur;

  logic                 is_lf;
  logic [BYTE_W-1:0]    diff;
  logic [ProdW-1:0]     prod;
  logic                 over;

  assign is_lf = rx_byte_i == CHAR_LF;
  assign diff  = rx_byte_i - CHAR_ZERO;
  assign prod  = ProdW'(cnt_q) * ProdW'(bound_i.clus);

  // count exceeds (end-start)/cluster+1, division truncating toward zero
  always_comb begin
    if (!bound_i.neg) begin
      over = prod > (ProdW'(bound_i.mag) + ProdW'(bound_i.clus));
    end else begin
      over = (cnt_q >= CntW'(2))
          || ((cnt_q == CntW'(1)) && (bound_i.mag >= STEP_W'(bound_i.clus)))
          || ((cnt_q == '0) && ({1'b0, bound_i.mag} >= ((STEP_W + 1)'(bound_i.clus) << 1)));
    end
  end

  always_comb begin
    phase_cur = start_of_reply_i ? PH_ECHO : phase_q;
    plf_cur   = start_of_reply_i ? 1'b0 : plf_q;
    sec_cur   = start_of_reply_i ? 1'b0 : sec_q;
    hi_cur    = start_of_reply_i ? '0 : hi_q;
    cnt_cur   = start_of_reply_i ? '0 : cnt_q;

    phase_d = phase_cur;
    plf_d   = plf_cur;
    sec_d   = sec_cur;
    hi_d    = hi_cur;
    cnt_d   = cnt_cur;

    res_o.emit  = 1'b0;
    res_o.kind  = KIND_READING;
    res_o.value = '0;
    res_o.last  = 1'b0;

    case (phase_cur)
      PH_ECHO: begin
        if (is_lf) phase_d = PH_STATUS_FIRST;
      end
      PH_STATUS_FIRST: begin
        if (rx_byte_i != CHAR_ZERO) begin
          phase_d    = PH_DONE;
          res_o.emit = 1'b1;
          res_o.kind = KIND_STATUS_ERR;
          res_o.last = 1'b1;
        end else begin
          phase_d = PH_STATUS_REST;
        end
      end
      PH_STATUS_REST: begin
        if (is_lf) begin
          phase_d = PH_DATA;
          plf_d   = 1'b0;
          sec_d   = 1'b0;
        end
      end
      PH_DATA: begin
        if (plf_cur && is_lf) begin
          phase_d    = PH_DONE;
          res_o.emit = 1'b1;
          res_o.kind = over ? KIND_TOO_MANY : KIND_END_OK;
          res_o.last = 1'b1;
        end else begin
          plf_d = is_lf;
          if (is_lf) begin
            sec_d = 1'b0;
          end else if (!sec_cur) begin
            hi_d  = diff[DIGIT_W-1:0];
            sec_d = 1'b1;
          end else begin
            sec_d       = 1'b0;
            cnt_d       = (cnt_cur < CntMax) ? cnt_cur + CntW'(1) : cnt_cur;
            res_o.emit  = 1'b1;
            res_o.value = {hi_cur, diff[DIGIT_W-1:0]};
          end
        end
      end
      default: ;
    endcase

    res_o.count = COUNT_W'(cnt_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_ECHO;
      plf_q   <= 1'b0;
      sec_q   <= 1'b0;
      hi_q    <= '0;
      cnt_q   <= '0;
    end else if (step_i) begin
      phase_q <= phase_d;
      plf_q   <= plf_d;
      sec_q   <= sec_d;
      hi_q    <= hi_d;
      cnt_q   <= cnt_d;
    end
  end

  `LRRD_ASSERT(a_cnt_sat, cnt_q <= CntMax, "reading count beyond limit")
  `LRRD_ASSERT_NEXT(a_last_done, step_i && res_o.emit && res_o.last, phase_q == PH_DONE,
    "reply end did not close the parser")
  `LRRD_ASSERT(a_done_quiet, (phase_q == PH_DONE) && !start_of_reply_i |-> !res_o.emit,
    "result after reply end")

endmodule

// ===== rtl/laser_range_reply_decoder_core.sv =====
// Path: a byte's result is offered from the result register, the byte having
// first passed the input register.
// Throughput: one byte per cycle; the input stalls only while a result waits.
// Reset: asynchronous, active low; parser returns to the echo line, count to
// zero, registers to start 0, end 768, cluster 1.
module laser_range_reply_decoder_core
  import lrrd_pkg::*;
#(
  parameter int unsigned ReadingLimit = READING_LIMIT_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [STEP_W-1:0]    cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [BYTE_W-1:0]    rx_byte_i,
  input  logic                 start_of_reply_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [1:0]           result_kind_o,
  output logic [VALUE_W-1:0]   reading_value_o,
  output logic [COUNT_W-1:0]   reading_count_o,
  output logic                 last_o
);

`include "laser_range_reply_decoder_core_macros.svh"

  lrrd_bound_t        bound;
  lrrd_res_t          res;

  logic               in_vld_q;
  logic [BYTE_W-1:0]  byte_q;
  logic               sor_q;

  logic               out_vld_q;
  lrrd_kind_e         kind_q;
  logic [VALUE_W-1:0] value_q;
  logic [COUNT_W-1:0] count_q;
  logic               last_q;

  logic               out_free;
  logic               step;

  assign out_free   = !out_vld_q || !out_stall_i;
  assign step       = in_vld_q && out_free;
  assign in_stall_o = in_vld_q && !out_free;

  lrrd_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .bound_o    (bound)
  );

  lrrd_parser #(
    .ReadingLimit (ReadingLimit)
  ) u_parser (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .step_i           (step),
    .rx_byte_i        (byte_q),
    .start_of_reply_i (sor_q),
    .bound_i          (bound),
    .res_o            (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        in_vld_q <= 1'b1;
      end else if (step) begin
        in_vld_q <= 1'b0;
      end
      if (out_free) begin
        out_vld_q <= step && res.emit;
      end
    end
  end

  // hold payload until the next transfer
  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      byte_q <= rx_byte_i;
      sor_q  <= start_of_reply_i;
    end
    if (step && res.emit) begin
      kind_q  <= res.kind;
      value_q <= res.value;
      count_q <= res.count;
      last_q  <= res.last;
    end
  end

  assign out_valid_o     = out_vld_q;
  assign result_kind_o   = kind_q;
  assign reading_value_o = value_q;
  assign reading_count_o = count_q;
  assign last_o          = last_q;

  `LRRD_ASSERT(a_stall_back, in_vld_q && out_vld_q && out_stall_i |-> in_stall_o,
    "input advanced over a waiting result")
  `LRRD_ASSERT_NEXT(a_out_load, step, out_vld_q == $past(res.emit),
    "result register out of step with parser")
  `LRRD_ASSERT(a_value_zero, out_vld_q && (kind_q != KIND_READING) |-> value_q == '0,
    "end result carries a range value")

endmodule

// ===== tb/tb.sv =====
module tb;
  import lrrd_pkg::*;

  localparam int CYCLE_LIMIT = 600000;
  localparam int MAX_REPORTS = 10;
  localparam int RANDOM_ITEMS = 1000;
  localparam int STREAM_ITEMS = 1270;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  typedef enum logic [2:0] {
    PARSE_ECHO,
    PARSE_STATUS_FIRST,
    PARSE_STATUS_REST,
    PARSE_DATA,
    PARSE_DONE
  } parse_phase_e;

  typedef struct {
    lrrd_kind_e         kind;
    logic [VALUE_W-1:0] value;
    logic [COUNT_W-1:0] count;
    logic               last;
  } range_result_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = CFG_START_STEP;
  logic [STEP_W-1:0]    cfg_data_i = '0;
  logic                 in_valid_i = 1'b0;
  logic                 in_stall_o;
  logic [BYTE_W-1:0]    rx_byte_i = '0;
  logic                 start_of_reply_i = 1'b0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  logic [1:0]           result_kind_o;
  logic [VALUE_W-1:0]   reading_value_o;
  logic [COUNT_W-1:0]   reading_count_o;
  logic                 last_o;

  // expected decoder state and registers
  logic [STEP_W-1:0]    cfg_start = START_STEP_RST;
  logic [STEP_W-1:0]    cfg_end = END_STEP_RST;
  logic [CLUS_W-1:0]    cfg_clus = CLUSTER_SIZE_RST;
  parse_phase_e         parse_phase = PARSE_ECHO;
  logic                 prev_lf = 1'b0;
  logic                 second_digit = 1'b0;
  logic [DIGIT_W-1:0]   high_digit = '0;
  int                   decoded_count = 0;

  range_result_t        pending_results[$];
  int                   mismatch_count = 0;
  int                   items_sent = 0;
  int                   cycle_count = 0;
  bit                   idling_on = 1'b1;

  laser_range_reply_decoder_core i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .rx_byte_i       (rx_byte_i),
    .start_of_reply_i(start_of_reply_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .result_kind_o   (result_kind_o),
    .reading_value_o (reading_value_o),
    .reading_count_o (reading_count_o),
    .last_o          (last_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    out_stall_i <= idling_on && ($urandom_range(99) < 22);
  end

  function automatic int reading_bound();
    int c;
    c = (cfg_clus == 0) ? 1 : int'(cfg_clus);
    return (int'(cfg_end) - int'(cfg_start)) / c + 1;
  endfunction

  function automatic void push_result(lrrd_kind_e kind, logic [VALUE_W-1:0] value,
                                      logic last);
    range_result_t r;
    r.kind  = kind;
    r.value = value;
    r.count = COUNT_W'(decoded_count);
    r.last  = last;
    pending_results.push_back(r);
  endfunction

  function automatic void decode_byte(logic [BYTE_W-1:0] b, logic sor);
    logic               lf;
    logic [DIGIT_W-1:0] digit;
    lf = (b == CHAR_LF);
    digit = DIGIT_W'(b - CHAR_ZERO);
    if (sor) begin
      parse_phase   = PARSE_ECHO;
      prev_lf       = 1'b0;
      second_digit  = 1'b0;
      high_digit    = '0;
      decoded_count = 0;
    end
    case (parse_phase)
      PARSE_ECHO: begin
        if (lf) parse_phase = PARSE_STATUS_FIRST;
      end
      PARSE_STATUS_FIRST: begin
        if (b != CHAR_ZERO) begin
          parse_phase = PARSE_DONE;
          push_result(KIND_STATUS_ERR, '0, 1'b1);
        end else begin
          parse_phase = PARSE_STATUS_REST;
        end
      end
      PARSE_STATUS_REST: begin
        if (lf) begin
          parse_phase  = PARSE_DATA;
          prev_lf      = 1'b0;
          second_digit = 1'b0;
        end
      end
      PARSE_DATA: begin
        if (prev_lf && lf) begin
          parse_phase = PARSE_DONE;
          push_result((decoded_count > reading_bound()) ? KIND_TOO_MANY : KIND_END_OK,
                      '0, 1'b1);
        end else begin
          prev_lf = lf;
          if (lf) begin
            second_digit = 1'b0;
          end else if (!second_digit) begin
            high_digit   = digit;
            second_digit = 1'b1;
          end else begin
            second_digit = 1'b0;
            if (decoded_count < READING_LIMIT_DEF) decoded_count++;
            push_result(KIND_READING, {high_digit, digit}, 1'b0);
          end
        end
      end
      default: ;
    endcase
  endfunction

  always @(posedge clk_i) begin
    range_result_t exp_r;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (pending_results.size() == 0) begin
          if (mismatch_count < MAX_REPORTS)
            $display("unexpected result: kind %0d value %0d count %0d last %0d",
                     result_kind_o, reading_value_o, reading_count_o, last_o);
          mismatch_count++;
        end else begin
          exp_r = pending_results.pop_front();
          if (result_kind_o !== exp_r.kind || reading_value_o !== exp_r.value ||
              reading_count_o !== exp_r.count || last_o !== exp_r.last) begin
            if (mismatch_count < MAX_REPORTS)
              $display("mismatch (expected/actual): kind %0d/%0d value %0d/%0d ",
                       exp_r.kind, result_kind_o, exp_r.value, reading_value_o,
                       "count %0d/%0d last %0d/%0d",
                       exp_r.count, reading_count_o, exp_r.last, last_o);
            mismatch_count++;
          end
        end
      end
      if (in_valid_i && !in_stall_o) decode_byte(rx_byte_i, start_of_reply_i);
    end
  end

  task automatic send_byte(logic [BYTE_W-1:0] b, logic sor);
    if (idling_on && $urandom_range(99) < 22) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
      while ($urandom_range(99) < 22) @(posedge clk_i);
    end
    in_valid_i       <= 1'b1;
    rx_byte_i        <= b;
    start_of_reply_i <= sor;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    items_sent++;
  endtask

  task automatic send_text(string s, logic sor);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], sor && (i == 0));
  endtask

  // hold off until every expected transfer has come out
  task automatic settle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [STEP_W-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    case (idx)
      CFG_START_STEP:   cfg_start = data;
      CFG_END_STEP:     cfg_end = data;
      CFG_CLUSTER_SIZE: cfg_clus = data[CLUS_W-1:0];
      default: ;
    endcase
  endtask

  task automatic write_config(int start_v, int end_v, int clus_v);
    settle();
    write_reg(CFG_START_STEP, STEP_W'(start_v));
    write_reg(CFG_END_STEP, STEP_W'(end_v));
    write_reg(CFG_CLUSTER_SIZE, STEP_W'(clus_v));
  endtask

  function automatic logic [BYTE_W-1:0] text_char();
    logic [BYTE_W-1:0] b;
    do b = BYTE_W'($urandom); while (b == CHAR_LF);
    return b;
  endfunction

  function automatic logic [BYTE_W-1:0] data_char();
    if ($urandom_range(99) < 85) return BYTE_W'($urandom_range(8'h30, 8'h6F));
    return text_char();
  endfunction

  task automatic send_reply(int readings, bit bad_status, bit truncate);
    bit                first;
    int                remaining;
    int                pairs;
    logic [BYTE_W-1:0] b;
    first = 1'b1;
    repeat ($urandom_range(0, 5)) begin
      send_byte(text_char(), first);
      first = 1'b0;
    end
    send_byte(CHAR_LF, first);
    if (bad_status) begin
      do b = BYTE_W'($urandom); while (b == CHAR_ZERO);
      send_byte(b, 1'b0);
      return;
    end
    send_byte(CHAR_ZERO, 1'b0);
    repeat ($urandom_range(0, 2)) send_byte(text_char(), 1'b0);
    send_byte(CHAR_LF, 1'b0);
    remaining = readings;
    while (remaining > 0) begin
      pairs = $urandom_range(1, 6);
      if (pairs > remaining) pairs = remaining;
      repeat (pairs) begin
        send_byte(data_char(), 1'b0);
        send_byte(data_char(), 1'b0);
      end
      remaining -= pairs;
      if ($urandom_range(9) == 0) send_byte(data_char(), 1'b0);
      if (truncate) return;
      send_byte(CHAR_LF, 1'b0);
    end
    if (readings == 0) send_byte(CHAR_LF, 1'b0);
    send_byte(CHAR_LF, 1'b0);
    if ($urandom_range(9) == 0)
      repeat ($urandom_range(1, 3)) send_byte(BYTE_W'($urandom), 1'b0);
  endtask

  task automatic send_noise();
    logic [BYTE_W-1:0] b;
    repeat ($urandom_range(5, 30)) begin
      case ($urandom_range(9))
        0, 1, 2: b = CHAR_LF;
        3, 4:    b = CHAR_ZERO;
        default: b = BYTE_W'($urandom);
      endcase
      send_byte(b, $urandom_range(19) == 0);
    end
  endtask

  task automatic random_reply();
    int b;
    int sel;
    b = reading_bound();
    if (b < 0) b = 0;
    if (b > 24) b = 24;
    sel = $urandom_range(99);
    if (sel < 70)      send_reply($urandom_range(0, b + 2), 1'b0, 1'b0);
    else if (sel < 80) send_reply(0, 1'b1, 1'b0);
    else if (sel < 90) send_reply($urandom_range(1, b + 2), 1'b0, 1'b1);
    else               send_noise();
  endtask

  task automatic random_config();
    int start_v;
    int end_v;
    start_v = $urandom_range(0, 1023);
    if ($urandom_range(3) == 0) begin
      write_config(start_v, $urandom_range(0, 1023), $urandom_range(0, 127));
    end else begin
      end_v = start_v + $urandom_range(0, 23);
      if (end_v > 1023) end_v = 1023;
      write_config(start_v, end_v, $urandom_range(1, 4));
    end
  endtask

  task automatic test_directed();
    send_text("M\n", 1'b1);
    send_text("\n", 1'b0);
    send_text("x", 1'b0);
    send_text("M\n1", 1'b1);
    send_text("\n0\n", 1'b1);
    send_byte(8'h30, 1'b0);
    send_byte(8'h30, 1'b0);
    send_byte(8'h6F, 1'b0);
    send_byte(8'h6F, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_text("5\n\n", 1'b0);
  endtask

  task automatic test_config_extremes();
    write_config(1023, 0, 99);
    write_reg(CFG_UNUSED, STEP_W'($urandom));
    send_reply(0, 1'b0, 1'b0);
    write_config(0, 2, 0);
    send_reply(3, 1'b0, 1'b0);
    send_reply(4, 1'b0, 1'b0);
    write_config(0, 1023, 99);
    send_reply(11, 1'b0, 1'b0);
    send_reply(12, 1'b0, 1'b0);
    write_config(5, 3, 1);
    send_reply(0, 1'b0, 1'b0);
    write_config(3, 1, 2);
    send_reply(0, 1'b0, 1'b0);
    send_reply(1, 1'b0, 1'b0);
  endtask

  task automatic test_random_replies();
    while (items_sent < RANDOM_ITEMS) begin
      random_config();
      repeat ($urandom_range(4, 8)) random_reply();
    end
  endtask

  task automatic test_streaming();
    settle();
    idling_on = 1'b0;
    while (items_sent < STREAM_ITEMS) random_reply();
    settle();
    idling_on = 1'b1;
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_config_extremes();
    test_random_replies();
    test_streaming();
    settle();
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/lrrd_pkg.sv
rtl/lrrd_cfg.sv
rtl/lrrd_parser.sv
rtl/laser_range_reply_decoder_core.sv
tb/tb.sv
